// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Field widths, character codes, datapath actions, sequencer conditions and
// the microprogram that steps the console through each request.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Geometry defaults.
  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  // Request and result field widths.
  localparam int OP_W     = 1;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int DATA_W   = 16;
  localparam int COLOUT_W = 7;
  localparam int ROWOUT_W = 5;
  localparam int ATTR_W   = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OP_W-1:0] OP_READ = 1'b1;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  // Tab stops fall on multiples of a power of two.
  localparam int TAB_STOP = 4;
  localparam int TAB_BITS = $clog2(TAB_STOP);

  // Datapath actions, one per microinstruction.
  typedef enum logic [3:0] {
    A_NONE,
    A_CLEAR,
    A_ACCEPT,
    A_READ,
    A_PUT_CHAR,
    A_PUT_SPACE,
    A_NEWLINE,
    A_RETURN,
    A_RESULT,
    A_CNT_CLR,
    A_COPY,
    A_FILL
  } action_t;

  // Next-step selection.
  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_IN,
    C_DECODE,
    C_SCROLL,
    C_TABSTOP,
    C_COUNT,
    C_OUTFREE,
    C_RET
  } cond_t;

  // Kind of the request held in the datapath.
  typedef enum logic [2:0] {
    CLS_READ,
    CLS_TAB,
    CLS_NEWLINE,
    CLS_RETURN,
    CLS_PLAIN
  } item_class_t;

  typedef logic [3:0] step_t;

  // Microprogram step addresses.
  localparam step_t S_CLEAR    = 4'd0;
  localparam step_t S_IDLE     = 4'd1;
  localparam step_t S_DECODE   = 4'd2;
  localparam step_t S_READ     = 4'd3;
  localparam step_t S_PUT      = 4'd4;
  localparam step_t S_NEWLINE  = 4'd5;
  localparam step_t S_RETURN   = 4'd6;
  localparam step_t S_TAB      = 4'd7;
  localparam step_t S_TABCHK   = 4'd8;
  localparam step_t S_RES      = 4'd9;
  localparam step_t S_SC_START = 4'd10;
  localparam step_t S_SC_COPY  = 4'd11;
  localparam step_t S_SC_DRAIN = 4'd12;
  localparam step_t S_SC_FILL  = 4'd13;
  localparam step_t S_SC_END   = 4'd14;

  typedef struct packed {
    action_t action;
    cond_t   cond;
    step_t   target;
  } ctrl_word_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    action_t action;
  } ctrl_t;

  // Status handed from the datapath to the sequencer.
  typedef struct packed {
    logic        in_fire;
    item_class_t item_class;
    logic        scroll_hit;
    logic        off_stop;
    logic        cnt_last;
    logic        out_free;
  } status_t;

  // The microprogram.
  function automatic ctrl_word_t micro_rom(input step_t step);
    ctrl_word_t cw;
    unique case (step)
      S_CLEAR:    cw = '{A_CLEAR,     C_COUNT,   S_IDLE};
      S_IDLE:     cw = '{A_ACCEPT,    C_IN,      S_DECODE};
      S_DECODE:   cw = '{A_NONE,      C_DECODE,  S_IDLE};
      S_READ:     cw = '{A_READ,      C_JUMP,    S_RES};
      S_PUT:      cw = '{A_PUT_CHAR,  C_SCROLL,  S_RES};
      S_NEWLINE:  cw = '{A_NEWLINE,   C_SCROLL,  S_RES};
      S_RETURN:   cw = '{A_RETURN,    C_JUMP,    S_RES};
      S_TAB:      cw = '{A_PUT_SPACE, C_SCROLL,  S_TABCHK};
      S_TABCHK:   cw = '{A_NONE,      C_TABSTOP, S_TAB};
      S_RES:      cw = '{A_RESULT,    C_OUTFREE, S_IDLE};
      S_SC_START: cw = '{A_CNT_CLR,   C_NEXT,    S_IDLE};
      S_SC_COPY:  cw = '{A_COPY,      C_COUNT,   S_IDLE};
      S_SC_DRAIN: cw = '{A_CNT_CLR,   C_NEXT,    S_IDLE};
      S_SC_FILL:  cw = '{A_FILL,      C_COUNT,   S_IDLE};
      S_SC_END:   cw = '{A_NONE,      C_RET,     S_IDLE};
      default:    cw = '{A_NONE,      C_JUMP,    S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// File: design/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: request and result channels of the text console writer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::OP_W-1:0]     operation;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::INDEX_W-1:0]  cell_index;

  modport source (output valid, output operation, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input operation, input char_code, input cell_index,
                output ready);
endinterface

interface tcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::DATA_W-1:0]    cell_data;
  logic [tcw_pkg::COLOUT_W-1:0]  cursor_column;
  logic [tcw_pkg::ROWOUT_W-1:0]  cursor_row;

  modport source (output valid, output cell_data, output cursor_column,
                  output cursor_row, input ready);
  modport sink (input valid, input cell_data, input cursor_column, input cursor_row,
                output ready);
endinterface

// File: design/tcw_sequencer.sv
// ----------------------------------------------------------------------------
// tcw_sequencer: microprogram counter of the text console writer
// Fetches one control word a cycle and picks the next step from its condition.
// ----------------------------------------------------------------------------
module tcw_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  tcw_pkg::status_t status,
  output tcw_pkg::ctrl_t   ctrl
);

  tcw_pkg::step_t     pc;
  tcw_pkg::step_t     pc_next;
  tcw_pkg::step_t     ret;
  tcw_pkg::step_t     ret_next;
  tcw_pkg::ctrl_word_t cw;
  tcw_pkg::step_t     pc_inc;

  assign cw          = tcw_pkg::micro_rom(pc);
  assign pc_inc      = tcw_pkg::step_t'(pc + 1'b1);
  assign ctrl.action = cw.action;

  always_comb begin
    pc_next  = pc;
    ret_next = ret;
    unique case (cw.cond)
      tcw_pkg::C_NEXT:    pc_next = pc_inc;
      tcw_pkg::C_JUMP:    pc_next = cw.target;
      tcw_pkg::C_IN:      pc_next = status.in_fire ? cw.target : pc;
      tcw_pkg::C_DECODE: begin
        unique case (status.item_class)
          tcw_pkg::CLS_READ:    pc_next = tcw_pkg::S_READ;
          tcw_pkg::CLS_TAB:     pc_next = tcw_pkg::S_TAB;
          tcw_pkg::CLS_NEWLINE: pc_next = tcw_pkg::S_NEWLINE;
          tcw_pkg::CLS_RETURN:  pc_next = tcw_pkg::S_RETURN;
          default:              pc_next = tcw_pkg::S_PUT;
        endcase
      end
      // A cursor move off the last row calls the scroll routine, which
      // comes back to the target.
      tcw_pkg::C_SCROLL: begin
        if (status.scroll_hit) begin
          pc_next  = tcw_pkg::S_SC_START;
          ret_next = cw.target;
        end else begin
          pc_next = cw.target;
        end
      end
      tcw_pkg::C_TABSTOP: pc_next = status.off_stop ? cw.target : pc_inc;
      tcw_pkg::C_COUNT:   pc_next = status.cnt_last ? pc_inc : pc;
      tcw_pkg::C_OUTFREE: pc_next = status.out_free ? cw.target : pc;
      tcw_pkg::C_RET:     pc_next = ret;
      default:            pc_next = tcw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= tcw_pkg::S_CLEAR;
      ret <= tcw_pkg::S_IDLE;
    end else begin
      pc  <= pc_next;
      ret <= ret_next;
    end
  end

endmodule

// File: design/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath: screen memory, cursor and result register
// Carries out the action that the sequencer selects each cycle.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata,
  input  tcw_pkg::ctrl_t              ctrl,
  output tcw_pkg::status_t            status,
  tcw_in_if.sink                      request,
  tcw_out_if.source                   response
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);
  localparam int CMPW       = (AW + 1 > tcw_pkg::INDEX_W) ? AW + 1 : tcw_pkg::INDEX_W;
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);

  logic [tcw_pkg::DATA_W-1:0] mem [CELL_COUNT];

  logic [tcw_pkg::ATTR_W-1:0]  attribute;
  logic [tcw_pkg::OP_W-1:0]    op_reg;
  logic [tcw_pkg::CHAR_W-1:0]  char_reg;
  logic [tcw_pkg::INDEX_W-1:0] index_reg;
  logic [CW-1:0]               col;
  logic [RW-1:0]               row;
  logic [AW-1:0]               addr;
  logic [AW-1:0]               cnt;
  logic                        copy_v;
  logic [AW-1:0]               copy_addr;
  logic [tcw_pkg::DATA_W-1:0]  rdata;
  logic                        out_valid;
  logic [tcw_pkg::DATA_W-1:0]  out_data;
  logic [tcw_pkg::COLOUT_W-1:0] out_col;
  logic [tcw_pkg::ROWOUT_W-1:0] out_row;

  logic                        in_fire;
  logic                        out_free;
  logic                        col_last;
  logic                        row_last;
  logic                        in_range;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [tcw_pkg::DATA_W-1:0]  wdata;
  logic                        re;
  logic [AW-1:0]               raddr;

  assign request.ready = (ctrl.action == tcw_pkg::A_ACCEPT);
  assign in_fire       = request.valid && request.ready;
  assign out_free      = !out_valid || response.ready;
  assign col_last      = (col == CW'(COLUMNS - 1));
  assign row_last      = (row == RW'(ROWS - 1));
  assign in_range      = (CMPW'(index_reg) < CMPW'(CELL_COUNT));

  assign response.valid         = out_valid;
  assign response.cell_data     = out_data;
  assign response.cursor_column = out_col;
  assign response.cursor_row    = out_row;

  // Status toward the sequencer.
  always_comb begin
    status.in_fire  = in_fire;
    status.out_free = out_free;
    status.off_stop = (col[tcw_pkg::TAB_BITS-1:0] != '0);
    if (op_reg == tcw_pkg::OP_READ) begin
      status.item_class = tcw_pkg::CLS_READ;
    end else if (char_reg == tcw_pkg::CH_TAB) begin
      status.item_class = tcw_pkg::CLS_TAB;
    end else if (char_reg == tcw_pkg::CH_NEWLINE) begin
      status.item_class = tcw_pkg::CLS_NEWLINE;
    end else if (char_reg == tcw_pkg::CH_RETURN) begin
      status.item_class = tcw_pkg::CLS_RETURN;
    end else begin
      status.item_class = tcw_pkg::CLS_PLAIN;
    end
    unique case (ctrl.action)
      tcw_pkg::A_PUT_CHAR,
      tcw_pkg::A_PUT_SPACE: status.scroll_hit = col_last && row_last;
      tcw_pkg::A_NEWLINE:   status.scroll_hit = row_last;
      default:              status.scroll_hit = 1'b0;
    endcase
    unique case (ctrl.action)
      tcw_pkg::A_CLEAR: status.cnt_last = (cnt == AW'(CELL_COUNT - 1));
      tcw_pkg::A_COPY:  status.cnt_last = (cnt == AW'(CELL_COUNT - COLUMNS - 1));
      tcw_pkg::A_FILL:  status.cnt_last = (cnt == AW'(COLUMNS - 1));
      default:          status.cnt_last = 1'b0;
    endcase
  end

  // Memory port selection. The write half of a row copy lands in the cycle
  // after its read and takes priority.
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (copy_v) begin
      we    = 1'b1;
      waddr = copy_addr;
      wdata = rdata;
    end else begin
      unique case (ctrl.action)
        tcw_pkg::A_CLEAR: begin
          we    = 1'b1;
          waddr = cnt;
        end
        tcw_pkg::A_FILL: begin
          we    = 1'b1;
          waddr = AW'(LAST_ROW_BASE + cnt);
        end
        tcw_pkg::A_PUT_CHAR: begin
          we    = 1'b1;
          wdata = {attribute, char_reg};
        end
        tcw_pkg::A_PUT_SPACE: begin
          we    = 1'b1;
          wdata = {attribute, tcw_pkg::CH_SPACE};
        end
        default: we = 1'b0;
      endcase
    end
  end

  assign re    = (ctrl.action == tcw_pkg::A_READ) || (ctrl.action == tcw_pkg::A_COPY);
  assign raddr = (ctrl.action == tcw_pkg::A_COPY) ? AW'(cnt + AW'(COLUMNS))
                                                  : AW'(index_reg);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_reg    <= request.operation;
      char_reg  <= request.char_code;
      index_reg <= request.cell_index;
    end
    copy_addr <= cnt;
    if (ctrl.action == tcw_pkg::A_RESULT && out_free) begin
      out_data <= (op_reg == tcw_pkg::OP_READ && in_range) ? rdata : '0;
      out_col  <= tcw_pkg::COLOUT_W'(col);
      out_row  <= tcw_pkg::ROWOUT_W'(row);
    end
  end

  // Control state, cursor and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tcw_pkg::ATTR_RESET;
      col       <= '0;
      row       <= '0;
      addr      <= '0;
      cnt       <= '0;
      copy_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        attribute <= cfg_wdata;
      end
      copy_v <= (ctrl.action == tcw_pkg::A_COPY);
      if (ctrl.action == tcw_pkg::A_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.action)
        tcw_pkg::A_PUT_CHAR,
        tcw_pkg::A_PUT_SPACE: begin
          if (!col_last) begin
            col  <= CW'(col + 1'b1);
            addr <= AW'(addr + 1'b1);
          end else begin
            col <= '0;
            if (row_last) begin
              addr <= LAST_ROW_BASE;
            end else begin
              row  <= RW'(row + 1'b1);
              addr <= AW'(addr + 1'b1);
            end
          end
        end
        tcw_pkg::A_NEWLINE: begin
          col <= '0;
          if (row_last) begin
            addr <= LAST_ROW_BASE;
          end else begin
            row  <= RW'(row + 1'b1);
            addr <= AW'(addr - AW'(col) + AW'(COLUMNS));
          end
        end
        tcw_pkg::A_RETURN: begin
          col  <= '0;
          addr <= AW'(addr - AW'(col));
        end
        tcw_pkg::A_CLEAR,
        tcw_pkg::A_COPY,
        tcw_pkg::A_FILL:    cnt <= AW'(cnt + 1'b1);
        tcw_pkg::A_CNT_CLR: cnt <= '0;
        default: ;
      endcase
    end
  end

endmodule

// File: design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console with a scrolling screen memory
// A microprogrammed sequencer steps a small datapath through each request.
// ----------------------------------------------------------------------------
// Each request is taken, decoded and carried out, and its result is then
// loaded into the result register once that register is free; only then is
// the next request taken. A tab writes one space at a time, checking after
// each for a tab stop. A scroll copies or blanks one cell a cycle through the
// screen memory. After reset a clearing pass zeroes the screen; no request
// is taken then, but configuration writes are.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
  tcw_in_if.sink                     request,
  tcw_out_if.source                  response
);

  // The sequencer owns the step counter and the microprogram; it tells the
  // datapath what to do through ctrl and branches on what status reports.
  tcw_pkg::ctrl_t   ctrl;
  tcw_pkg::status_t status;

  tcw_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // The datapath holds the screen memory, the cursor, the attribute register
  // and the result register. Scrolling copies each row up by one, then
  // fills the bottom row with zeros, while the sequencer holds off requests.
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .status    (status),
    .request   (request),
    .response  (response)
  );

endmodule

// File: verif/text_console_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Drives put and read requests through the valid/ready channels with random
// gaps and stalls, predicts every response from a private copy of the screen,
// cursor and attribute, and compares the responses field by field in order.
// ----------------------------------------------------------------------------
package tcw_tb_pkg;
  import tcw_pkg::*;

  localparam int SCREEN_COLS  = DEFAULT_COLUMNS;
  localparam int SCREEN_ROWS  = DEFAULT_ROWS;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

  typedef struct packed {
    logic [DATA_W-1:0]   cell_data;
    logic [COLOUT_W-1:0] cursor_column;
    logic [ROWOUT_W-1:0] cursor_row;
  } console_result_t;

  // Shadow of the console: screen memory, cursor and attribute, plus the
  // responses that the accepted requests are still owed.
  class console_scoreboard;
    logic [DATA_W-1:0] screen [SCREEN_CELLS];
    int unsigned       cursor_col;
    int unsigned       cursor_row;
    logic [ATTR_W-1:0] attr;
    console_result_t   owed_responses[$];
    int                failures;
    int                results_seen;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cursor_col   = 0;
      cursor_row   = 0;
      attr         = ATTR_RESET;
      failures     = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return owed_responses.size();
    endfunction

    // Moves down one row; below the last row the screen scrolls up one line
    // and the bottom row is blanked.
    function void advance_line();
      cursor_row++;
      if (cursor_row >= SCREEN_ROWS) begin
        for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) screen[i] = screen[i + SCREEN_COLS];
        for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) screen[i] = '0;
        cursor_row = SCREEN_ROWS - 1;
      end
    endfunction

    function void write_cell(logic [CHAR_W-1:0] ch);
      screen[cursor_row * SCREEN_COLS + cursor_col] = {attr, ch};
      cursor_col++;
      if (cursor_col >= SCREEN_COLS) begin
        cursor_col = 0;
        advance_line();
      end
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                               logic [INDEX_W-1:0] idx);
      console_result_t owed;
      owed.cell_data = '0;
      if (op == OP_READ) begin
        if (idx < SCREEN_CELLS) owed.cell_data = screen[idx];
      end else if (ch == CH_TAB) begin
        write_cell(CH_SPACE);
        while ((cursor_col % TAB_STOP) != 0) write_cell(CH_SPACE);
      end else if (ch == CH_NEWLINE) begin
        cursor_col = 0;
        advance_line();
      end else if (ch == CH_RETURN) begin
        cursor_col = 0;
      end else begin
        write_cell(ch);
      end
      owed.cursor_column = COLOUT_W'(cursor_col);
      owed.cursor_row    = ROWOUT_W'(cursor_row);
      owed_responses.push_back(owed);
    endfunction

    function void compare_field(string field, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic [COLOUT_W-1:0] col,
                               logic [ROWOUT_W-1:0] row);
      console_result_t owed;
      results_seen++;
      if (owed_responses.size() == 0) begin
        $display("%0t: response with none expected, actual %h col %0d row %0d",
                 $time, data, col, row);
        failures++;
        return;
      end
      owed = owed_responses.pop_front();
      compare_field("cell_data", owed.cell_data, data);
      compare_field("cursor_column", owed.cursor_column, col);
      compare_field("cursor_row", owed.cursor_row, row);
    endfunction
  endclass
endpackage

module text_console_writer_tb;
  import tcw_pkg::*;
  import tcw_tb_pkg::*;

  // The slowest correct request is a tab that scrolls, since the scroll moves
  // every cell of the screen, and each side may add the idle time of its drawn
  // waits and stalls on top. The limit covers every request taking
  // that long several times over, plus the clearing pass after reset.
  localparam longint CYCLE_LIMIT   = 20_000_000;
  localparam int     PHASE_ITEMS   = 367;
  localparam int     PHASE_COUNT   = 5;
  localparam int     HOLD_AT       = 600;
  localparam int     HOLD_CYCLES   = 500;
  localparam int     SETTLE_CYCLES = 50;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcw_in_if  request_bus ();
  tcw_out_if response_bus ();

  text_console_writer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .request  (request_bus),
    .response (response_bus)
  );

  console_scoreboard board = new();

  longint cycle_count = 0;
  int     requests_sent = 0;
  int     source_calm = 0;
  int     sink_calm = 0;

  always #5 clk = ~clk;

  // A hung block must not hang the run; the counter is the only timeout.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Each side draws its wait per request. Now and then it enters a calm
  // stretch of back-to-back requests so the block also sees full rate.
  function automatic int draw_wait(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid
  // is only lowered when a gap is drawn, so consecutive requests with no gap
  // keep it high without a second assignment in the same time step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx);
    int gap;
    gap = draw_wait(source_calm);
    if (gap > 0) begin
      request_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_bus.valid      <= 1'b1;
    request_bus.operation  <= op;
    request_bus.char_code  <= ch;
    request_bus.cell_index <= idx;
    @(posedge clk);
    while (!request_bus.ready) @(posedge clk);
    board.note_request(op, ch, idx);
    requests_sent++;
  endtask

  // The index is ignored by a put, so it carries random bits anyway.
  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_request(OP_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
  endtask

  // Likewise the character is ignored by a read.
  task automatic read_cell(input int unsigned idx);
    send_request(OP_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(idx));
  endtask

  // Mostly printable text, with tabs, high bytes and the odd arbitrary byte.
  function automatic logic [CHAR_W-1:0] text_char();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return CHAR_W'($urandom_range(32, 126));
    if (pick == 7) return CH_TAB;
    if (pick == 8) return CHAR_W'($urandom_range(128, 255));
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Drops valid and waits until every owed response has come back, which
  // leaves the block idle for a configuration write.
  task automatic drain_responses();
    request_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.attr = value;
  endtask

  // Random traffic shaped like console output: lines of text that run long
  // enough to wrap, bursts of newlines that scroll the screen, read-back of
  // the rows near the cursor, overwrites after a return, and some noise.
  task automatic send_random_batch(input int count);
    int target;
    int kind;
    int len;
    int unsigned base_row;
    target = requests_sent + count;
    while (requests_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(0, 90);
        for (int i = 0; i < len; i++) put_char(text_char());
        case ($urandom_range(0, 3))
          0: ;
          1: begin
            put_char(CH_RETURN);
            put_char(CH_NEWLINE);
          end
          default: put_char(CH_NEWLINE);
        endcase
      end else if (kind < 60) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          base_row = board.cursor_row - $urandom_range(0, 1);
          if (base_row >= SCREEN_ROWS) base_row = 0;
          if ($urandom_range(0, 4) == 0)
            read_cell($urandom_range(0, 2047));
          else
            read_cell(base_row * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1));
        end
      end else if (kind < 70) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) put_char(CH_NEWLINE);
      end else if (kind < 80) begin
        put_char(CH_RETURN);
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) put_char(text_char());
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send_request(OP_W'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                       INDEX_W'($urandom_range(0, 2047)));
      end
    end
  endtask

  // Response side. It runs on its own, drawing a stall per response, and
  // once, after a fixed number of responses, it holds off for a long stretch
  // while the request side keeps offering, so the block backs up.
  initial begin : response_sink
    int stall;
    response_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait(sink_calm);
      if (board.results_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        response_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      response_bus.ready <= 1'b1;
      @(posedge clk);
      while (!response_bus.valid) @(posedge clk);
      board.check_result(response_bus.cell_data, response_bus.cursor_column,
                         response_bus.cursor_row);
    end
  end

  initial begin : request_source
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    request_bus.valid      <= 1'b0;
    request_bus.operation  <= OP_PUT;
    request_bus.char_code  <= '0;
    request_bus.cell_index <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under the reset attribute. The block is still
    // clearing its screen, so the first request simply waits for ready.
    // Low, high and sign-bit bytes land in the first cells.
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h80);
    put_char("A");
    // A tab that starts on a stop writes four spaces; one that starts past
    // a stop only fills up to the next one.
    put_char(CH_TAB);
    put_char("B");
    put_char(CH_TAB);
    // Carriage return goes back to column zero, so the next byte overwrites.
    put_char(CH_RETURN);
    put_char("C");
    put_char(CH_NEWLINE);
    // Read back the written cells, the last cell on screen and indexes past
    // the end of the screen, which must read as zero.
    read_cell(0);
    read_cell(2);
    read_cell(8);
    read_cell(SCREEN_CELLS - 1);
    read_cell(SCREEN_CELLS);
    read_cell(2047);
    drain_responses();

    // Random phases, each under its own attribute. The extremes come first;
    // the request side waits for every response between phases.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       write_attribute(8'hFF);
        1:       write_attribute(8'h00);
        default: write_attribute(ATTR_W'($urandom_range(0, 255)));
      endcase
      send_random_batch(PHASE_ITEMS);
      drain_responses();
    end

    // Give a stray extra response time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
